[rtl/wmmd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the waveform min-max decimator.
// No dependencies.
package wmmd_pkg;

	localparam int MAX_CHANNELS     = 8;
	localparam int MAX_BLOCK_FRAMES = 65536;

	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
	localparam int FRM_W   = $clog2(MAX_BLOCK_FRAMES);
	localparam int FPB_W   = 17;
	localparam int LVL_W   = 16;
	localparam int OUT_W   = 17;
	localparam int SMP_W   = 16;
	localparam int CFG_W   = 17;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] REG_FRAMES_PER_BLOCK  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_CHANNEL_COUNT     = 2'd1;
	localparam logic [CIDX_W-1:0] REG_SAMPLE_WIDTH_MODE = 2'd2;

	localparam logic [LVL_W-1:0] SIGN_FLIP = 16'h8000;
	localparam logic [LVL_W-1:0] BYTE_MASK = 16'h00FF;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            first;
		logic            last_ch;
		logic            emit;
	} pos_t;

endpackage

[rtl/wmmd_ctrl.sv]
`timescale 1ns / 1ps
// Channel and frame position tracker of the min-max decimator.
// Depends on wmmd_pkg.
module wmmd_ctrl import wmmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             end_of_data,
	input  logic [FPB_W-1:0] frames_per_block,
	input  logic [3:0]       channel_count,
	output pos_t             pos
);

	logic [CH_W-1:0]  chan_pos_q;
	logic [FRM_W-1:0] frame_cnt_q;
	logic [FPB_W-1:0] eff_frames;
	logic [CNT_W-1:0] eff_chans;
	logic             last_frame;

	always_comb begin
		if (frames_per_block == '0) begin
			eff_frames = FPB_W'(1);
		end else if (frames_per_block > FPB_W'(MAX_BLOCK_FRAMES)) begin
			eff_frames = FPB_W'(MAX_BLOCK_FRAMES);
		end else begin
			eff_frames = frames_per_block;
		end
		if (channel_count == '0) begin
			eff_chans = CNT_W'(1);
		end else if (channel_count > 4'(MAX_CHANNELS)) begin
			eff_chans = CNT_W'(MAX_CHANNELS);
		end else begin
			eff_chans = CNT_W'(channel_count);
		end
		last_frame  = (FPB_W'(frame_cnt_q) + FPB_W'(1)) >= eff_frames;
		pos.ch      = chan_pos_q;
		pos.first   = (frame_cnt_q == '0);
		pos.last_ch = (CNT_W'(chan_pos_q) + CNT_W'(1)) >= eff_chans;
		pos.emit    = last_frame | end_of_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_pos_q  <= '0;
			frame_cnt_q <= '0;
		end else if (accept) begin
			if (pos.last_ch) begin
				chan_pos_q <= '0;
				if (pos.emit) begin
					frame_cnt_q <= '0;
				end else begin
					frame_cnt_q <= frame_cnt_q + FRM_W'(1);
				end
			end else begin
				chan_pos_q <= chan_pos_q + CH_W'(1);
			end
		end
	end

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last_ch |=> chan_pos_q == '0)
		else $error("channel position did not wrap after last channel");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last_ch && pos.emit |=> frame_cnt_q == '0)
		else $error("frame counter did not restart at block end");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(chan_pos_q) && $stable(frame_cnt_q))
		else $error("position moved without an item");

endmodule

[rtl/waveform_minmax_decimator_unit.sv]
`timescale 1ns / 1ps
// Top level of the waveform min-max decimator: config registers, level memory, fold stage.
// Depends on wmmd_pkg and wmmd_ctrl.
// One sample item is taken per clock while input ready is high. The per-channel min/max
// memory is read when the item is taken, the item is folded and written back from the
// fold stage, and the result sits in an output register. A result for the same
// channel as the item just ahead is forwarded round the memory, so no bubble appears.
// Input ready drops only while a result waits in the output register and the fold stage
// also holds one.
module waveform_minmax_decimator_unit import wmmd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SMP_W-1:0]        sample_value,
	input  logic                    end_of_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              channel_index,
	output logic signed [OUT_W-1:0] min_level,
	output logic signed [OUT_W-1:0] max_level,
	output logic                    last_in_block
);

	logic [FPB_W-1:0] frames_per_block_q;
	logic [3:0]       channel_count_q;
	logic             mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_per_block_q <= FPB_W'(1);
			channel_count_q    <= 4'd1;
			mode_q             <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES_PER_BLOCK:  frames_per_block_q <= cfg_data;
				REG_CHANNEL_COUNT:     channel_count_q    <= cfg_data[3:0];
				REG_SAMPLE_WIDTH_MODE: mode_q             <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic accept;
	pos_t pos;

	wmmd_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.end_of_data      (end_of_data),
		.frames_per_block (frames_per_block_q),
		.channel_count    (channel_count_q),
		.pos              (pos)
	);

	logic [LVL_W-1:0] level;
	assign level = mode_q ? (sample_value ^ SIGN_FLIP) : (sample_value & BYTE_MASK);

	// fold stage
	logic             valid_s1;
	pos_t             pos_s1;
	logic [LVL_W-1:0] level_s1;
	logic             byp_s1;
	logic [LVL_W-1:0] byp_min_s1, byp_max_s1;
	logic [LVL_W-1:0] rd_min_q, rd_max_q;
	logic [LVL_W-1:0] cur_min, cur_max, new_min, new_max;
	logic             s1_adv, out_free;

	logic [2*LVL_W-1:0] lvl_mem [MAX_CHANNELS];

	assign out_free = !out_valid || out_ready;
	assign s1_adv   = !pos_s1.emit || out_free;
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cur_min = byp_s1 ? byp_min_s1 : rd_min_q;
		cur_max = byp_s1 ? byp_max_s1 : rd_max_q;
		if (pos_s1.first) begin
			new_min = level_s1;
			new_max = level_s1;
		end else begin
			new_min = (level_s1 < cur_min) ? level_s1 : cur_min;
			new_max = (level_s1 > cur_max) ? level_s1 : cur_max;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			lvl_mem[pos_s1.ch] <= {new_min, new_max};
		end
		if (accept) begin
			{rd_min_q, rd_max_q} <= lvl_mem[pos.ch];
			pos_s1     <= pos;
			level_s1   <= level;
			byp_min_s1 <= new_min;
			byp_max_s1 <= new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			byp_s1   <= valid_s1 && (pos_s1.ch == pos.ch);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end
	end

	// output register
	logic out_valid_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && pos_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && pos_s1.emit) begin
			channel_index <= 3'(pos_s1.ch);
			min_level     <= OUT_W'(0) - OUT_W'(new_min);
			max_level     <= OUT_W'(0) - OUT_W'(new_max);
			last_in_block <= pos_s1.last_ch;
		end
	end

	a_byp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> valid_s1)
		else $error("forwarding flag without an item in the fold stage");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");
	a_fold_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(pos_s1) && $stable(level_s1))
		else $error("stalled fold stage lost its item");

endmodule

[sim/minmax_peak_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the waveform min-max decimator: follows config writes, folds each accepted
// sample item into its own per-channel min/max and checks every result item in order.
// Depends on wmmd_pkg.
module minmax_peak_checker import wmmd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [SMP_W-1:0]        sample_value,
	input  logic                    end_of_data,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [2:0]              channel_index,
	input  logic signed [OUT_W-1:0] min_level,
	input  logic signed [OUT_W-1:0] max_level,
	input  logic                    last_in_block,
	output int                      mismatch_count,
	output int                      peaks_outstanding
);

	typedef struct packed {
		logic [2:0]       ch;
		logic [OUT_W-1:0] lo;
		logic [OUT_W-1:0] hi;
		logic             last;
	} peak_t;

	peak_t            peak_queue[$];
	peak_t            head;
	logic [FPB_W-1:0] block_frames;
	logic [3:0]       lane_setting;
	logic             wide_samples;
	int unsigned      lane_pos;
	int unsigned      frame_pos;
	logic [OUT_W-1:0] lane_min[MAX_CHANNELS];
	logic [OUT_W-1:0] lane_max[MAX_CHANNELS];

	task automatic fold_sample(input logic [SMP_W-1:0] raw, input logic eod);
		int unsigned      frames;
		int unsigned      lanes;
		int unsigned      ch;
		logic [OUT_W-1:0] level;
		logic             last_lane;
		logic             last_frame;
		peak_t            p;
		frames = (block_frames == 0) ? 1 : block_frames;
		if (frames > MAX_BLOCK_FRAMES) frames = MAX_BLOCK_FRAMES;
		lanes = (lane_setting == 0) ? 1 : lane_setting;
		if (lanes > MAX_CHANNELS) lanes = MAX_CHANNELS;
		ch = (lane_pos >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : lane_pos;
		level = wide_samples ? OUT_W'(raw ^ SIGN_FLIP) : OUT_W'(raw & BYTE_MASK);

		// first frame of a block seeds both levels
		if (frame_pos == 0) begin
			lane_min[ch] = level;
			lane_max[ch] = level;
		end else begin
			if (level < lane_min[ch]) lane_min[ch] = level;
			if (level > lane_max[ch]) lane_max[ch] = level;
		end

		last_lane  = (ch + 1) >= lanes;
		last_frame = (frame_pos + 1) >= frames;
		if (last_lane) begin
			lane_pos  = 0;
			frame_pos = (last_frame || eod) ? 0 : frame_pos + 1;
		end else begin
			lane_pos = ch + 1;
		end

		if (last_frame || eod) begin
			p.ch   = 3'(ch);
			p.lo   = {OUT_W{1'b0}} - lane_min[ch];
			p.hi   = {OUT_W{1'b0}} - lane_max[ch];
			p.last = last_lane;
			peak_queue.push_back(p);
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames = 1;
			lane_setting = 1;
			wide_samples = 1'b0;
			lane_pos     = 0;
			frame_pos    = 0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				lane_min[i] = '0;
				lane_max[i] = '0;
			end
			peak_queue.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (peak_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result item, channel %0d", $time,
							channel_index);
				end else begin
					head = peak_queue.pop_front();
					check_field("channel_index", head.ch, channel_index);
					check_field("min_level", $signed(head.lo), min_level);
					check_field("max_level", $signed(head.hi), max_level);
					check_field("last_in_block", head.last, last_in_block);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAMES_PER_BLOCK:  block_frames = cfg_data[FPB_W-1:0];
					REG_CHANNEL_COUNT:     lane_setting = cfg_data[3:0];
					REG_SAMPLE_WIDTH_MODE: wide_samples = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) fold_sample(sample_value, end_of_data);
		end
		peaks_outstanding <= peak_queue.size();
	end

endmodule

[sim/tb_waveform_minmax_decimator_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the waveform min-max decimator: config writes, sample items with random
// idling on both channels, and the verdict taken from minmax_peak_checker.
// Depends on wmmd_pkg, waveform_minmax_decimator_unit and minmax_peak_checker.
module tb_waveform_minmax_decimator_unit;
	import wmmd_pkg::*;

	localparam logic MODE_8BIT      = 1'b0;
	localparam logic MODE_16BIT     = 1'b1;
	localparam int   RANDOM_SAMPLES = 1550;

	typedef enum int {FLUSH_NONE, FLUSH_LAST, FLUSH_ALL} flush_e;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CIDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [SMP_W-1:0]        sample_value;
	logic                    end_of_data;
	logic                    out_valid;
	logic                    out_ready;
	logic [2:0]              channel_index;
	logic signed [OUT_W-1:0] min_level;
	logic signed [OUT_W-1:0] max_level;
	logic                    last_in_block;
	int                      mismatch_count;
	int                      peaks_outstanding;

	int                      sent_count;
	int unsigned             lane_count;
	bit                      tx_busy;
	bit                      rx_busy;

	waveform_minmax_decimator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.end_of_data   (end_of_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.min_level     (min_level),
		.max_level     (max_level),
		.last_in_block (last_in_block)
	);

	minmax_peak_checker peak_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample_value      (sample_value),
		.end_of_data       (end_of_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.channel_index     (channel_index),
		.min_level         (min_level),
		.max_level         (max_level),
		.last_in_block     (last_in_block),
		.mismatch_count    (mismatch_count),
		.peaks_outstanding (peaks_outstanding)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap(input bit busy);
		int r;
		if (!busy) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			4:       return 16'h00FF;
			5:       return 16'h0080;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic [SMP_W-1:0] raw, input logic eod);
		int gap;
		gap = pick_gap(tx_busy);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= raw;
		end_of_data  <= eod;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	task automatic send_frames(input int frames, input int eod_odds, input flush_e flush);
		logic eod;
		for (int f = 0; f < frames; f++) begin
			for (int c = 0; c < lane_count; c++) begin
				eod = (eod_odds != 0) && ($urandom_range(0, eod_odds - 1) == 0);
				if (f == frames - 1) begin
					if (flush == FLUSH_ALL) eod = 1'b1;
					else if (flush == FLUSH_LAST && c == lane_count - 1) eod = 1'b1;
				end
				push_sample(pick_sample(), eod);
			end
		end
	endtask

	// drop valid and wait for every outstanding result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (peaks_outstanding != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_W-1:0] frames, input logic [3:0] chans,
			input logic mode);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAMES_PER_BLOCK;
		cfg_data  <= frames;
		@(posedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data  <= CFG_W'(chans);
		@(posedge clk);
		cfg_index <= REG_SAMPLE_WIDTH_MODE;
		cfg_data  <= CFG_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		lane_count = (chans == 0) ? 1 : chans;
		if (lane_count > MAX_CHANNELS) lane_count = MAX_CHANNELS;
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = pick_gap(rx_busy);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int random_start;
		int frames;
		int eod_odds;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_FRAMES_PER_BLOCK;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		sample_value <= '0;
		end_of_data  <= 1'b0;
		sent_count = 0;
		lane_count = 1;
		tx_busy    = 1'b1;
		rx_busy    = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every sample closes a one-frame block, low byte only
		push_sample(16'h00FF, 1'b0);
		push_sample(16'hFF00, 1'b0);
		settle();

		// zero length and zero channels act as one
		apply_config('0, 4'd0, MODE_16BIT);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7FFF, 1'b1);
		settle();

		// partial blocks: end of data on the whole last frame, then on its last sample only
		apply_config(CFG_W'(3), 4'd2, MODE_16BIT);
		send_frames(2, 0, FLUSH_ALL);
		send_frames(2, 0, FLUSH_LAST);
		settle();

		// frame shrunk mid-block: position 2 is past the new end and closes the block
		apply_config(CFG_W'(10), 4'd3, MODE_8BIT);
		send_frames(2, 0, FLUSH_NONE);
		push_sample(pick_sample(), 1'b0);
		push_sample(pick_sample(), 1'b0);
		settle();
		apply_config(CFG_W'(2), 4'd2, MODE_16BIT);
		push_sample(pick_sample(), 1'b0);
		send_frames(1, 0, FLUSH_LAST);
		settle();

		random_start = sent_count;
		while (sent_count - random_start < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 15))
				0:       frames = 0;
				1:       frames = $urandom_range(MAX_BLOCK_FRAMES + 1, 2 ** FPB_W - 1);
				2:       frames = MAX_BLOCK_FRAMES;
				3, 4:    frames = $urandom_range(9, 40);
				default: frames = $urandom_range(1, 8);
			endcase
			tx_busy = ($urandom_range(0, 4) != 0);
			rx_busy = ($urandom_range(0, 4) != 0);
			apply_config(CFG_W'(frames), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			eod_odds = ($urandom_range(0, 2) == 0) ? $urandom_range(3, 40) : 0;
			send_frames($urandom_range(1, 96 / lane_count), eod_odds,
				($urandom_range(0, 1) != 0) ? FLUSH_ALL : FLUSH_LAST);
			settle();
		end

		if (mismatch_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/wmmd_pkg.sv
rtl/wmmd_ctrl.sv
rtl/waveform_minmax_decimator_unit.sv
sim/minmax_peak_checker.sv
sim/tb_waveform_minmax_decimator_unit.sv
